/* rtl/fomm_pkg.sv */
// Package for the field-oriented mecanum mixer: widths, sine coefficients,
// register indexes, mode and action codes. No dependencies.
package fomm_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 15;

  localparam int Z_W    = 31;
  localparam int TRIG_W = TRIG_FRAC_BITS + 2;
  localparam int PROD_W = 16 + TRIG_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int MULT_W = SUM_W + 16;
  localparam int ROT_W  = 32 + TRIG_FRAC_BITS;
  localparam int MIX_W  = ((MULT_W > ROT_W) ? MULT_W : ROT_W) + 1;
  localparam int MIX_SHIFT = 14 + TRIG_FRAC_BITS;
  localparam int Q_W    = MIX_W - MIX_SHIFT;

  localparam logic [Z_W-1:0] ONE_Q30 = Z_W'(64'd1073741824);
  localparam logic [30:0]    SIN_A   = 31'd1686629713;
  localparam logic [29:0]    SIN_B   = 30'd688904866;
  localparam logic [26:0]    SIN_C   = 27'd76016977;

  localparam logic [1:0] REG_DEADBAND  = 2'd0;
  localparam logic [1:0] REG_TRANSLATE = 2'd1;
  localparam logic [1:0] REG_ROTATE    = 2'd2;

  localparam logic [14:0] DEADBAND_RST  = 15'd819;
  localparam logic [14:0] TRANSLATE_RST = 15'd5000;
  localparam logic [14:0] ROTATE_RST    = 15'd3000;

  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_ON  = 2'd1;

  localparam logic [1:0] ACT_STOP  = 2'd0;
  localparam logic [1:0] ACT_DRIVE = 2'd1;
  localparam logic [1:0] ACT_NONE  = 2'd2;

endpackage

/* rtl/fomm_if.sv */
// Channel interfaces of the mecanum mixer: stick command in, wheel targets out.
// No dependencies.
interface fomm_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] stick_x;
  logic signed [15:0] stick_y;
  logic signed [15:0] stick_rot;
  logic signed [15:0] heading;
  logic        [1:0]  switch_mode;
  modport source(output valid, stick_x, stick_y, stick_rot, heading, switch_mode,
                 input ready);
  modport sink(input valid, stick_x, stick_y, stick_rot, heading, switch_mode,
               output ready);
endinterface

interface fomm_wheel_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  action;
  logic signed [15:0] left_front;
  logic signed [15:0] right_front;
  logic signed [15:0] left_back;
  logic signed [15:0] right_back;
  modport source(output valid, action, left_front, right_front, left_back, right_back,
                 input ready);
  modport sink(input valid, action, left_front, right_front, left_back, right_back,
               output ready);
endinterface

/* rtl/field_oriented_mecanum_mixer.sv */
// Field-oriented mecanum mixer: deadband, heading rotation, wheel mix.
// Depends on fomm_pkg and the channels in fomm_if.
//
//   channel  dir  payload
//   cmd      in   stick_x, stick_y, stick_rot, heading, switch_mode
//   wheel    out  action, left_front, right_front, left_back, right_back
//   wr_*     in   index 0 deadband, 1 translate_gain, 2 rotate_gain
//
// Ten register stages; one transfer per cycle while the wheel output is not stalled.
// Stage depth is set by the sine polynomial multipliers.
// A stalled output holds the whole pipe; rst clears the valid bits
// and reloads the registers.
module field_oriented_mecanum_mixer (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [14:0] wr_data,
  fomm_cmd_if.sink    cmd,
  fomm_wheel_if.source wheel
);
  import fomm_pkg::*;

  localparam int NS = 10;

  logic [14:0] deadband, translate_gain, rotate_gain;
  logic [NS-1:0] vld;
  logic [1:0] mode [NS];
  logic adv;

  assign adv = !(vld[NS-1] && !wheel.ready);
  assign cmd.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband       <= DEADBAND_RST;
      translate_gain <= TRANSLATE_RST;
      rotate_gain    <= ROTATE_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DEADBAND:  deadband       <= wr_data;
        REG_TRANSLATE: translate_gain <= wr_data;
        REG_ROTATE:    rotate_gain    <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], cmd.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode[0] <= cmd.switch_mode;
      for (int i = 1; i < NS; i++) mode[i] <= mode[i-1];
    end
  end

  // stages 1 to 5: deadband and phase, then the sine polynomial
  function automatic logic signed [15:0] dead(input logic signed [15:0] v,
                                              input logic [14:0] db);
    logic [16:0] mag;
    mag = v[15] ? 17'(-$signed({v[15], v})) : {1'b0, v};
    return (mag < {2'b00, db}) ? 16'sd0 : v;
  endfunction

  function automatic logic [Z_W-1:0] quarter_z(input logic [ANGLE_BITS-1:0] p);
    logic [29:0] zf;
    zf = 30'(p[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);
    return p[ANGLE_BITS-2] ? ONE_Q30 - {1'b0, zf} : {1'b0, zf};
  endfunction

  logic [31:0] hx;
  logic [ANGLE_BITS-1:0] ph [2];
  assign hx = {cmd.heading, 16'h0000};
  assign ph[0] = hx[31 -: ANGLE_BITS];
  assign ph[1] = ph[0] + (ANGLE_BITS)'(1 << (ANGLE_BITS - 2));

  logic signed [15:0] x1, y1, r1, x2, y2, r2, x3, y3, r3, x4, y4, r4, x5, y5, r5;
  logic [Z_W-1:0] z1 [2], z2 [2], z3 [2], z4 [2];
  logic [1:0] q1 [2], q2 [2], q3 [2], q4 [2];
  logic [Z_W-1:0] zz2 [2], zz3 [2];
  logic [29:0] u3 [2];
  logic [30:0] w4 [2];
  logic signed [TRIG_W-1:0] sc5 [2];

  logic [61:0] p_zz [2];
  logic [57:0] p_t [2];
  logic [60:0] p_v [2];
  logic [61:0] p_s [2];
  logic [Z_W-1:0] s_raw [2];
  logic [TRIG_W-1:0] s_rnd [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      p_zz[k] = 62'(z1[k]) * 62'(z1[k]);
      p_t[k]  = 58'(SIN_C) * 58'(zz2[k]);
      p_v[k]  = 61'(u3[k]) * 61'(zz3[k]);
      p_s[k]  = 62'(w4[k]) * 62'(z4[k]);
      s_raw[k] = p_s[k][60:30];
      s_rnd[k] = TRIG_W'((32'(s_raw[k]) + (32'd1 << (29 - TRIG_FRAC_BITS)))
                         >> (30 - TRIG_FRAC_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1 <= dead(cmd.stick_x, deadband);
      y1 <= dead(cmd.stick_y, deadband);
      r1 <= dead(cmd.stick_rot, deadband);
      x2 <= x1; y2 <= y1; r2 <= r1;
      x3 <= x2; y3 <= y2; r3 <= r2;
      x4 <= x3; y4 <= y3; r4 <= r3;
      x5 <= x4; y5 <= y4; r5 <= r4;
      for (int k = 0; k < 2; k++) begin
        z1[k] <= quarter_z(ph[k]);
        q1[k] <= ph[k][ANGLE_BITS-1 -: 2];
        zz2[k] <= p_zz[k][60:30];
        z2[k] <= z1[k]; q2[k] <= q1[k];
        u3[k] <= SIN_B - 30'(p_t[k][57:30]);
        zz3[k] <= zz2[k]; z3[k] <= z2[k]; q3[k] <= q2[k];
        w4[k] <= SIN_A - 31'(p_v[k][60:30]);
        z4[k] <= z3[k]; q4[k] <= q3[k];
        sc5[k] <= q4[k][1] ? -$signed(s_rnd[k]) : $signed(s_rnd[k]);
      end
    end
  end

  // stages 6 to 9: rotate, mix, gain
  logic signed [PROD_W-1:0] xc6, ys6, xs6, yc6;
  logic signed [31:0] rr6, rr7;
  logic signed [SUM_W-1:0] a7, d7;
  logic signed [MIX_W-1:0] at8, dt8, rt8;
  logic signed [MIX_W-1:0] lf9, rf9, lb9, rb9;
  logic signed [SUM_W-1:0] vx, vy;

  assign vx = SUM_W'(xc6) - SUM_W'(ys6);
  assign vy = SUM_W'(xs6) + SUM_W'(yc6);

  always_ff @(posedge clk) begin
    if (adv) begin
      xc6 <= PROD_W'(x5) * PROD_W'(sc5[1]);
      ys6 <= PROD_W'(y5) * PROD_W'(sc5[0]);
      xs6 <= PROD_W'(x5) * PROD_W'(sc5[0]);
      yc6 <= PROD_W'(y5) * PROD_W'(sc5[1]);
      rr6 <= 32'(r5) * $signed({17'd0, rotate_gain});
      a7  <= vx + vy;
      d7  <= vx - vy;
      rr7 <= rr6;
      at8 <= MIX_W'(a7) * $signed({(MIX_W-15)'(0), translate_gain});
      dt8 <= MIX_W'(d7) * $signed({(MIX_W-15)'(0), translate_gain});
      rt8 <= MIX_W'(rr7) <<< TRIG_FRAC_BITS;
      lf9 <= at8 + rt8;
      rf9 <= dt8 - rt8;
      lb9 <= dt8 + rt8;
      rb9 <= at8 - rt8;
    end
  end

  // stage 10: round half away from zero, saturate
  function automatic logic signed [15:0] rsat(input logic signed [MIX_W-1:0] v);
    logic [MIX_W-1:0] mag;
    logic [MIX_W-1:0] qf;
    logic [Q_W-1:0] q;
    mag = v[MIX_W-1] ? MIX_W'(-v) : MIX_W'(v);
    qf  = (mag + (MIX_W'(1) << (MIX_SHIFT - 1))) >> MIX_SHIFT;
    q   = qf[Q_W-1:0];
    if (v[MIX_W-1]) begin
      return (q > Q_W'(32768)) ? -16'sd32768 : 16'(-$signed({1'b0, q}));
    end
    return (q > Q_W'(32767)) ? 16'sd32767 : 16'(q);
  endfunction

  logic drive;
  assign drive = (mode[NS-2] == MODE_ON);

  always_ff @(posedge clk) begin
    if (adv) begin
      wheel.action      <= drive ? ACT_DRIVE : (mode[NS-2] == MODE_OFF ? ACT_STOP : ACT_NONE);
      wheel.left_front  <= drive ? rsat(lf9) : 16'sd0;
      wheel.right_front <= drive ? rsat(rf9) : 16'sd0;
      wheel.left_back   <= drive ? rsat(lb9) : 16'sd0;
      wheel.right_back  <= drive ? rsat(rb9) : 16'sd0;
    end
  end

  assign wheel.valid = vld[NS-1];

endmodule

/* tb/fomm_tb_if.sv */
`timescale 1ns / 100ps
// Testbench view of the mixer channels: reuses the RTL interfaces from fomm_if.
// This file only holds a small helper package of random field helpers.
// Depends on fomm_pkg.
package fomm_tb_pkg;
  import fomm_pkg::*;

  function automatic logic signed [15:0] rand_stick();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: rand_stick = 16'sd16384;
      1: rand_stick = -16'sd16384;
      2: rand_stick = 16'($urandom_range(0, 2000)) - 16'sd1000;
      3: rand_stick = 16'($urandom);
      default: rand_stick = 16'($urandom_range(0, 32768)) - 16'sd16384;
    endcase
  endfunction
endpackage

/* tb/fomm_checker.sv */
`timescale 1ns / 100ps
// Checker for the mecanum mixer: watches configuration writes and both channels,
// computes expected wheel targets and compares. Depends on fomm_pkg, fomm_if.
module fomm_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [14:0] wr_data,
  fomm_cmd_if         cmd,
  fomm_wheel_if       wheel,
  output int          errors,
  output int          pending
);
  import fomm_pkg::*;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] lf;
    logic [15:0] rf;
    logic [15:0] lb;
    logic [15:0] rb;
  } targets_t;

  logic [14:0] deadband_q, trans_gain_q, rot_gain_q;
  targets_t    targets_q[$];

  function automatic longint gate(logic signed [15:0] v);
    longint m;
    m = (v < 0) ? -longint'(v) : longint'(v);
    return (m < longint'(deadband_q)) ? 0 : longint'(v);
  endfunction

  function automatic longint sine_q15(logic [15:0] phase);
    logic [1:0] quad;
    longint unsigned z, z2, t, v, w, s;
    quad = phase[15:14];
    z = longint'(phase[13:0]) << 16;
    if (quad[0]) z = (64'd1 << 30) - z;
    z2 = (z * z) >> 30;
    t = (64'd76016977 * z2) >> 30;
    v = ((64'd688904866 - t) * z2) >> 30;
    w = 64'd1686629713 - v;
    s = (((w * z) >> 30) + (64'd1 << 14)) >> 15;
    return quad[1] ? -longint'(s) : longint'(s);
  endfunction

  function automatic logic [15:0] round_clip(longint v);
    longint unsigned mag, q;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    q = (mag + (64'd1 << 28)) >> 29;
    if (v < 0) return (q > 32768) ? 16'h8000 : 16'(-longint'(q));
    return (q > 32767) ? 16'h7fff : 16'(q);
  endfunction

  function automatic targets_t mix_wheels(logic signed [15:0] sx, logic signed [15:0] sy,
                                          logic signed [15:0] sr, logic [15:0] hdg,
                                          logic [1:0] mode);
    targets_t t;
    longint x, y, r, s, c, vx, vy, rt, tg;
    t = '0;
    if (mode != MODE_ON) begin
      t.action = (mode == MODE_OFF) ? ACT_STOP : ACT_NONE;
      return t;
    end
    x = gate(sx);
    y = gate(sy);
    r = gate(sr);
    s = sine_q15(hdg);
    c = sine_q15(hdg + 16'h4000);
    vx = x * c - y * s;
    vy = x * s + y * c;
    tg = longint'(trans_gain_q);
    rt = r * longint'(rot_gain_q) * 32768;
    t.action = ACT_DRIVE;
    t.lf = round_clip((vx + vy) * tg + rt);
    t.rf = round_clip((vx - vy) * tg - rt);
    t.lb = round_clip((vx - vy) * tg + rt);
    t.rb = round_clip((vx + vy) * tg - rt);
    return t;
  endfunction

  task automatic compare(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name,
               $signed(exp_v), $signed(act_v));
    end
  endtask

  always @(posedge clk) begin
    targets_t e;
    if (rst) begin
      deadband_q   <= DEADBAND_RST;
      trans_gain_q <= TRANSLATE_RST;
      rot_gain_q   <= ROTATE_RST;
      targets_q.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (cmd.valid && cmd.ready)
        targets_q.push_back(mix_wheels(cmd.stick_x, cmd.stick_y, cmd.stick_rot,
                                       cmd.heading, cmd.switch_mode));
      if (wheel.valid && wheel.ready) begin
        if (targets_q.size() == 0) begin
          errors++;
          $display("%0t unexpected wheel transfer", $time);
        end else begin
          e = targets_q.pop_front();
          compare("action", 16'(e.action), 16'(wheel.action));
          compare("left_front", e.lf, wheel.left_front);
          compare("right_front", e.rf, wheel.right_front);
          compare("left_back", e.lb, wheel.left_back);
          compare("right_back", e.rb, wheel.right_back);
        end
      end
      pending = targets_q.size();
      if (wr_en) begin
        case (wr_index)
          REG_DEADBAND:  deadband_q   <= wr_data;
          REG_TRANSLATE: trans_gain_q <= wr_data;
          REG_ROTATE:    rot_gain_q   <= wr_data;
          default: ;
        endcase
      end
    end
  end

endmodule

/* tb/tb_field_oriented_mecanum_mixer.sv */
`timescale 1ns / 100ps
// Top of the mecanum mixer testbench: clock, reset, command stimulus, register
// phases, verdict. Depends on fomm_pkg, fomm_tb_pkg, fomm_if, fomm_checker, mixer.
module tb_field_oriented_mecanum_mixer;
  import fomm_pkg::*;
  import fomm_tb_pkg::*;

  localparam int LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        wr_en = 1'b0;
  logic [1:0]  wr_index = '0;
  logic [14:0] wr_data = '0;
  int          errors, pending, cycles;
  logic        hold_off = 1'b0;
  logic        done = 1'b0;

  fomm_cmd_if   cmd();
  fomm_wheel_if wheel();

  field_oriented_mecanum_mixer dut (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .cmd(cmd), .wheel(wheel)
  );

  fomm_checker chk (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .cmd(cmd), .wheel(wheel), .errors(errors), .pending(pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    cmd.valid = 1'b0;
    cmd.stick_x = '0;
    cmd.stick_y = '0;
    cmd.stick_rot = '0;
    cmd.heading = '0;
    cmd.switch_mode = MODE_OFF;
    wheel.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= rst ? 0 : cycles + 1;
    if (cycles > LIMIT) begin
      $display("[field_oriented_mecanum_mixer] ERROR");
      $finish;
    end
  end

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk) begin
    int unsigned phase;
    phase = cycles % 64;
    if (rst || hold_off) wheel.ready <= 1'b0;
    else if (phase < 20) wheel.ready <= 1'b1;
    else wheel.ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic send(logic signed [15:0] sx, logic signed [15:0] sy,
                      logic signed [15:0] sr, logic signed [15:0] hdg, logic [1:0] mode);
    cmd.valid <= 1'b1;
    cmd.stick_x <= sx;
    cmd.stick_y <= sy;
    cmd.stick_rot <= sr;
    cmd.heading <= hdg;
    cmd.switch_mode <= mode;
    do @(posedge clk); while (!cmd.ready);
  endtask

  task automatic pause();
    cmd.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    cmd.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [14:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic random_burst(int n);
    int unsigned burst;
    logic [1:0] mode;
    while (n > 0) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && n > 0) begin
        mode = ($urandom_range(0, 9) < 8) ? MODE_ON : 2'($urandom);
        send(rand_stick(), rand_stick(), rand_stick(), 16'($urandom), mode);
        burst--;
        n--;
      end
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 6)) pause();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(16'sd16384, 16'sd0, 16'sd0, 16'sd0, MODE_ON);
    send(-16'sd16384, 16'sd16384, -16'sd16384, 16'sh4000, MODE_ON);
    send(16'sd16384, 16'sd16384, 16'sd16384, 16'sh8000, MODE_ON);
    send(-16'sd32768, -16'sd32768, -16'sd32768, 16'sh7fff, MODE_ON);
    send(16'sh7fff, 16'sh7fff, 16'sh7fff, -16'sd1, MODE_ON);
    send(16'sd818, -16'sd818, 16'sd819, 16'sh2000, MODE_ON);
    send(16'sd819, -16'sd819, -16'sd818, 16'shc000, MODE_ON);
    send(16'sd1000, 16'sd2000, 16'sd3000, 16'sh1234, MODE_OFF);
    send(16'sd1000, 16'sd2000, 16'sd3000, 16'sh1234, 2'd2);
    send(16'sd1000, 16'sd2000, 16'sd3000, 16'sh1234, 2'd3);
    send(16'sd0, 16'sd0, 16'sd0, 16'sha000, MODE_ON);
    drain();

    write_reg(REG_TRANSLATE, 15'd16384);
    write_reg(REG_ROTATE, 15'd16384);
    write_reg(REG_DEADBAND, 15'd0);
    write_reg(2'd3, 15'h7fff);
    send(16'sd16384, 16'sd16384, 16'sd16384, 16'sh2000, MODE_ON);
    send(-16'sd32768, 16'sd16384, -16'sd16384, 16'sh6000, MODE_ON);
    send(16'sd1, -16'sd1, 16'sd0, 16'sh0000, MODE_ON);
    random_burst(300);

    hold_off <= 1'b1;
    fork
      random_burst(60);
      begin
        repeat (200) @(posedge clk);
        hold_off <= 1'b0;
      end
    join
    drain();

    write_reg(REG_DEADBAND, 15'h7fff);
    write_reg(REG_TRANSLATE, 15'h7fff);
    write_reg(REG_ROTATE, 15'd0);
    random_burst(150);
    drain();

    write_reg(REG_DEADBAND, 15'd16384);
    write_reg(REG_TRANSLATE, 15'd0);
    write_reg(REG_ROTATE, 15'h7fff);
    random_burst(150);
    drain();

    for (int k = 0; k < 6; k++) begin
      write_reg(REG_DEADBAND, 15'($urandom_range(0, 3000)));
      write_reg(REG_TRANSLATE, 15'($urandom));
      write_reg(REG_ROTATE, 15'($urandom));
      random_burst(180);
      drain();
    end

    if (errors == 0) begin
      $display("[field_oriented_mecanum_mixer] OK");
    end else begin
      $display("[field_oriented_mecanum_mixer] ERROR");
    end
    $finish;
  end

endmodule
